/* design/keyed_generation_table_core_defines.svh */
// assertion macros for the keyed generation table core
// used by the top level only; assertions drop out when SYNTHESIS is defined
`ifndef KEYED_GENERATION_TABLE_CORE_DEFINES_SVH
`define KEYED_GENERATION_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, disabled while reset is low
`define KGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check, also evaluated during reset
`define KGT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define KGT_ASSERT(lbl, prop, msg)
`define KGT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* design/kgt_pkg.sv */
// shared types for the keyed generation table core
// no dependencies; used by kgt_cell, keyed_generation_table_core and the bench
`timescale 1ns / 1ps

package kgt_pkg;

  localparam int unsigned KindW  = 4;
  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    ModeAdd  = 1'b0,
    ModeFind = 1'b1
  } mode_e;

  // request held at the top and broadcast to every cell
  typedef struct packed {
    mode_e             mode;
    logic [KindW-1:0]  kind;
    logic [WordW-1:0]  subject;
    logic [WordW-1:0]  generation;
    logic [WordW-1:0]  epoch;
  } req_t;

  // token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              inserted;
    logic [WordW-1:0]  generation;
    logic [WordW-1:0]  epoch;
  } token_t;

  typedef struct packed {
    logic              accepted;
    logic              found;
    logic [WordW-1:0]  generation;
    logic [WordW-1:0]  epoch;
    logic              truncated;
    logic [CountW-1:0] entry_count;
  } result_t;

endpackage

/* design/keyed_generation_table_core.sv */
// Keyed generation table: up to MAX_ENTRIES entries keyed by kind and subject,
// each in a cell of its own. A request enters the first cell in the cycle after
// it is accepted and the search token moves one cell per clock through the cell
// registers; the result is written from the last cell into the output register.
// The next request is taken only once the scan is over, so a new request cannot
// be accepted before the last one has passed the whole cell chain. A finished
// result waits in an output register (with one
// spare slot) so the next request may be taken while it is unread; with both
// full the input stalls until the result is read. Entries need no clearing
// after reset: only slots below the entry count are matched.
`timescale 1ns / 1ps

`include "keyed_generation_table_core_defines.svh"

module keyed_generation_table_core
  import kgt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [KindW-1:0]  kind_i,
  input  logic [WordW-1:0]  subject_i,
  input  logic [WordW-1:0]  generation_i,
  input  logic [WordW-1:0]  epoch_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              accepted_o,
  output logic              found_o,
  output logic [WordW-1:0]  found_generation_o,
  output logic [WordW-1:0]  found_epoch_o,
  output logic              table_truncated_o,
  output logic [CountW-1:0] entry_count_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StScan = 2'b10
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q;
  logic              start_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              trunc_q, trunc_d;
  result_t           out_q, pend_q, res;
  logic              out_valid_q, pend_valid_q;
  logic              in_accept;
  logic              out_take;
  logic              rejected;
  logic [CntW+CountW-1:0] count_ext;

  token_t            tok [MAX_ENTRIES+1];
  token_t            tail;

  assign in_ready_o = (state_q == StIdle) && !pend_valid_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  // valid is the top bit of the token
  assign tok[0] = {start_q, {($bits(token_t)-1){1'b0}}};

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    kgt_cell #(
      .CntW(CntW),
      .Idx (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_q),
      .count_i(count_q),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  assign tail = tok[MAX_ENTRIES];

  // add with no match and no free slot
  assign rejected = (req_q.mode == ModeAdd) && !tail.hit && !tail.inserted;
  assign count_d  = count_q + CntW'(tail.inserted);
  assign trunc_d  = trunc_q || rejected;
  assign count_ext = {{CountW{1'b0}}, count_d};

  always_comb begin
    res.accepted    = (req_q.mode == ModeAdd) && (tail.hit || tail.inserted);
    res.found       = tail.hit;
    res.generation  = tail.generation;
    res.epoch       = tail.epoch;
    res.truncated   = trunc_d;
    res.entry_count = count_ext[CountW-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_accept) state_d = StScan;
      end
      StScan: begin
        if (tail.valid) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      start_q      <= 1'b0;
      count_q      <= '0;
      trunc_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_accept;
      if (tail.valid) begin
        count_q <= count_d;
        trunc_q <= trunc_d;
      end
      if (tail.valid) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          pend_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q  <= pend_valid_q;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.mode       <= mode_e'(mode_i);
      req_q.kind       <= kind_i;
      req_q.subject    <= subject_i;
      req_q.generation <= generation_i;
      req_q.epoch      <= epoch_i;
    end
    if (tail.valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        pend_q <= res;
      end
    end else if (out_take && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign accepted_o         = out_q.accepted;
  assign found_o            = out_q.found;
  assign found_generation_o = out_q.generation;
  assign found_epoch_o      = out_q.epoch;
  assign table_truncated_o  = out_q.truncated;
  assign entry_count_o      = out_q.entry_count;

  `KGT_ASSERT(a_no_accept_while_scanning, (state_q == StScan) |-> !in_ready_o, "request in scan")
  `KGT_ASSERT(a_tail_finds_free_slot, tail.valid |-> !pend_valid_q, "spare slot full")
  `KGT_ASSERT(a_hit_xor_insert, tail.valid |-> !(tail.hit && tail.inserted), "hit and insert")
  `KGT_ASSERT(a_count_bounded, count_q <= CntW'(MAX_ENTRIES), "count above size")

endmodule

/* design/kgt_cell.sv */
// one table entry plus one stage of the search token chain
// depends on kgt_pkg
`timescale 1ns / 1ps

module kgt_cell
  import kgt_pkg::*;
#(
  parameter int unsigned CntW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  req_t            req_i,
  input  logic [CntW-1:0] count_i,
  input  token_t          tok_i,
  output token_t          tok_o
);

  logic [KindW-1:0] kind_q;
  logic [WordW-1:0] subject_q;
  logic [WordW-1:0] gen_q;
  logic [WordW-1:0] epoch_q;
  token_t           tok_q, tok_d;

  logic             used;
  logic             match;
  logic             upd;
  logic             ins;
  logic [WordW-1:0] new_gen;

  assign used    = CntW'(Idx) < count_i;
  assign match   = tok_i.valid && !tok_i.hit && used &&
                   (kind_q == req_i.kind) && (subject_q == req_i.subject);
  assign upd     = match && (req_i.mode == ModeAdd);
  // first unused slot takes the key when no earlier cell held it
  assign ins     = tok_i.valid && !tok_i.hit && (req_i.mode == ModeAdd) &&
                   (CntW'(Idx) == count_i);
  assign new_gen = (req_i.generation > gen_q) ? req_i.generation : gen_q;

  always_comb begin
    tok_d = tok_i;
    if (upd) begin
      tok_d.hit        = 1'b1;
      tok_d.generation = new_gen;
      tok_d.epoch      = req_i.epoch;
    end else if (match) begin
      tok_d.hit        = 1'b1;
      tok_d.generation = gen_q;
      tok_d.epoch      = epoch_q;
    end else if (ins) begin
      tok_d.inserted   = 1'b1;
      tok_d.generation = req_i.generation;
      tok_d.epoch      = req_i.epoch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins) begin
      kind_q    <= req_i.kind;
      subject_q <= req_i.subject;
    end
    if (upd || ins) begin
      gen_q   <= upd ? new_gen : req_i.generation;
      epoch_q <= req_i.epoch;
    end
  end

  assign tok_o = tok_q;

endmodule

/* sim/keyed_generation_table_core_tb.sv */
// self-checking bench for keyed_generation_table_core: directed table, then random
// add/find traffic against an in-bench copy of the keyed table; needs kgt_pkg
`timescale 1ns / 1ps

module keyed_generation_table_core_tb;
  import kgt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned KEY_POOL     = 96;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned NARROW_ITEMS = 400;
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [63:0] ONES         = '1;
  localparam logic [63:0] TOP_BIT      = 64'h8000_0000_0000_0000;

  typedef struct {
    req_t    req;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              in_valid_i         = 1'b0;
  logic              in_ready_o;
  logic              mode_i             = 1'b0;
  logic [KindW-1:0]  kind_i             = '0;
  logic [WordW-1:0]  subject_i          = '0;
  logic [WordW-1:0]  generation_i       = '0;
  logic [WordW-1:0]  epoch_i            = '0;
  logic              out_valid_o;
  logic              out_ready_i        = 1'b0;
  logic              accepted_o;
  logic              found_o;
  logic [WordW-1:0]  found_generation_o;
  logic [WordW-1:0]  found_epoch_o;
  logic              table_truncated_o;
  logic [CountW-1:0] entry_count_o;

  // in-bench copy of the keyed table
  logic [KindW-1:0] tbl_kind       [TABLE_DEPTH];
  logic [WordW-1:0] tbl_subject    [TABLE_DEPTH];
  logic [WordW-1:0] tbl_generation [TABLE_DEPTH];
  logic [WordW-1:0] tbl_epoch      [TABLE_DEPTH];
  int unsigned      tbl_used      = 0;
  bit               tbl_truncated = 1'b0;

  result_t     awaited_results[$];
  stim_row_t   directed_rows[$];
  logic [KindW-1:0] pool_kind    [KEY_POOL];
  logic [WordW-1:0] pool_subject [KEY_POOL];

  int unsigned send_idle_pct  = 38;
  int unsigned recv_idle_pct  = 54;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  result_t     got;
  result_t     want;

  keyed_generation_table_core #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .kind_i            (kind_i),
    .subject_i         (subject_i),
    .generation_i      (generation_i),
    .epoch_i           (epoch_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .accepted_o        (accepted_o),
    .found_o           (found_o),
    .found_generation_o(found_generation_o),
    .found_epoch_o     (found_epoch_o),
    .table_truncated_o (table_truncated_o),
    .entry_count_o     (entry_count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // add one row to the end of the directed table
  function automatic void append_row(input req_t r, input bit typed, input result_t row_want);
    stim_row_t row;
    row.req       = r;
    row.typed     = typed;
    row.want      = row_want;
    directed_rows = {directed_rows, row};
  endfunction

  // apply one request to the table copy and return the result it should produce
  function automatic result_t table_step(input req_t r);
    result_t res;
    int      hit_idx;
    int      i;
    res     = '0;
    hit_idx = -1;
    for (i = 0; i < int'(tbl_used); i++) begin
      if (hit_idx < 0 && tbl_kind[i] == r.kind && tbl_subject[i] == r.subject) hit_idx = i;
    end
    if (r.mode == ModeAdd) begin
      if (hit_idx >= 0) begin
        if (r.generation > tbl_generation[hit_idx]) tbl_generation[hit_idx] = r.generation;
        tbl_epoch[hit_idx] = r.epoch;
        res.accepted   = 1'b1;
        res.found      = 1'b1;
        res.generation = tbl_generation[hit_idx];
        res.epoch      = tbl_epoch[hit_idx];
      end else if (tbl_used >= TABLE_DEPTH) begin
        tbl_truncated = 1'b1;
      end else begin
        tbl_kind[tbl_used]       = r.kind;
        tbl_subject[tbl_used]    = r.subject;
        tbl_generation[tbl_used] = r.generation;
        tbl_epoch[tbl_used]      = r.epoch;
        tbl_used++;
        res.accepted   = 1'b1;
        res.generation = r.generation;
        res.epoch      = r.epoch;
      end
    end else if (hit_idx >= 0) begin
      res.found      = 1'b1;
      res.generation = tbl_generation[hit_idx];
      res.epoch      = tbl_epoch[hit_idx];
    end
    res.truncated   = tbl_truncated;
    res.entry_count = CountW'(tbl_used);
    return res;
  endfunction

  // present one request, hold it until taken, then queue what it should return
  task automatic issue_request(input req_t r, input bit typed, input result_t typed_want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= r.mode;
    kind_i       <= r.kind;
    subject_i    <= r.subject;
    generation_i <= r.generation;
    epoch_i      <= r.epoch;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = table_step(r);
    if (typed) predicted = typed_want;
    awaited_results = {awaited_results, predicted};
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.accepted    = accepted_o;
      got.found       = found_o;
      got.generation  = found_generation_o;
      got.epoch       = found_epoch_o;
      got.truncated   = table_truncated_o;
      got.entry_count = entry_count_o;
      if (awaited_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("result with no request outstanding: acc=%0d found=%0d gen=%h ep=%h",
                   got.accepted, got.found, got.generation, got.epoch);
        end
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got.accepted !== want.accepted || got.found !== want.found ||
            got.generation !== want.generation || got.epoch !== want.epoch ||
            got.truncated !== want.truncated || got.entry_count !== want.entry_count) begin
          if (mismatch_count < 10) begin
            $display("mismatch: want acc=%0d found=%0d gen=%h ep=%h trunc=%0d count=%0d",
                     want.accepted, want.found, want.generation, want.epoch,
                     want.truncated, want.entry_count);
            $display("          got  acc=%0d found=%0d gen=%h ep=%h trunc=%0d count=%0d",
                     got.accepted, got.found, got.generation, got.epoch,
                     got.truncated, got.entry_count);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    req_t        r;
    int unsigned n;
    int unsigned pick;
    int unsigned slot;
    int unsigned sel;

    // key pool with near neighbors: same subject other kind, one subject bit apart
    for (n = 0; n < KEY_POOL; n++) begin
      if (n % 8 == 3) begin
        pool_kind[n]    = pool_kind[n-1] ^ 4'(1 + $urandom_range(0, 14));
        pool_subject[n] = pool_subject[n-1];
      end else if (n % 8 == 5) begin
        pool_kind[n]    = pool_kind[n-1];
        pool_subject[n] = pool_subject[n-1] ^ (64'h1 << $urandom_range(0, 63));
      end else begin
        pool_kind[n]    = 4'($urandom_range(0, 15));
        pool_subject[n] = rand64();
      end
    end

    // empty table, extremes, max-generation rule, kind-only and subject-only misses
    append_row(req_t'{ModeFind, 4'h0, 64'h0, 64'h0, 64'h0}, 1'b1,
               result_t'{1'b0, 1'b0, 64'h0, 64'h0, 1'b0, 7'd0});
    append_row(req_t'{ModeAdd, 4'h0, 64'h0, 64'h0, 64'h0}, 1'b1,
               result_t'{1'b1, 1'b0, 64'h0, 64'h0, 1'b0, 7'd1});
    append_row(req_t'{ModeAdd, 4'hf, ONES, ONES, ONES}, 1'b1,
               result_t'{1'b1, 1'b0, ONES, ONES, 1'b0, 7'd2});
    append_row(req_t'{ModeFind, 4'hf, ONES, 64'h0, 64'h0}, 1'b1,
               result_t'{1'b0, 1'b1, ONES, ONES, 1'b0, 7'd2});
    append_row(req_t'{ModeFind, 4'he, ONES, 64'h0, 64'h0}, 1'b1,
               result_t'{1'b0, 1'b0, 64'h0, 64'h0, 1'b0, 7'd2});
    append_row(req_t'{ModeFind, 4'hf, ~TOP_BIT, 64'h0, 64'h0}, 1'b1,
               result_t'{1'b0, 1'b0, 64'h0, 64'h0, 1'b0, 7'd2});
    append_row(req_t'{ModeAdd, 4'hf, ONES, 64'd5, 64'd3}, 1'b1,
               result_t'{1'b1, 1'b1, ONES, 64'd3, 1'b0, 7'd2});
    append_row(req_t'{ModeAdd, 4'h0, 64'h0, 64'd10, ONES}, 1'b1,
               result_t'{1'b1, 1'b1, 64'd10, ONES, 1'b0, 7'd2});
    append_row(req_t'{ModeAdd, 4'h0, 64'h0, 64'd9, 64'd7}, 1'b1,
               result_t'{1'b1, 1'b1, 64'd10, 64'd7, 1'b0, 7'd2});
    append_row(req_t'{ModeAdd, 4'h0, 64'h0, 64'd10, 64'd8}, 1'b1,
               result_t'{1'b1, 1'b1, 64'd10, 64'd8, 1'b0, 7'd2});
    // find ignores offered generation and epoch
    append_row(req_t'{ModeFind, 4'h0, 64'h0, ONES, ONES}, 1'b1,
               result_t'{1'b0, 1'b1, 64'd10, 64'd8, 1'b0, 7'd2});
    append_row(req_t'{ModeAdd, 4'hd, TOP_BIT, TOP_BIT, 64'h1}, 1'b0, '0);
    append_row(req_t'{ModeAdd, 4'h1, {4{16'h5555}}, {4{16'haaaa}},
                      {4{16'h5555}}}, 1'b0, '0);
    append_row(req_t'{ModeAdd, 4'h2, {4{16'haaaa}}, {4{16'h5555}},
                      {4{16'haaaa}}}, 1'b0, '0);
    append_row(req_t'{ModeFind, 4'hd, TOP_BIT, 64'h0, 64'h0}, 1'b0, '0);
    append_row(req_t'{ModeAdd, 4'he, 64'h0, 64'h1, 64'h2}, 1'b0, '0);
    append_row(req_t'{ModeFind, 4'h0, 64'h0, 64'h0, 64'h0}, 1'b0, '0);
    append_row(req_t'{ModeFind, 4'hc, 64'h1, 64'h0, 64'h0}, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // narrow key set first so updates hit before the table fills, then the full set
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 38;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick   = $urandom_range(0, 99);
      r.mode = (pick < 55) ? ModeAdd : ModeFind;
      slot   = (n < NARROW_ITEMS) ? $urandom_range(0, 47) : $urandom_range(0, KEY_POOL - 1);
      r.kind    = pool_kind[slot];
      r.subject = pool_subject[slot];
      if ($urandom_range(0, 9) == 0 && (n >= NARROW_ITEMS || r.mode == ModeFind)) begin
        r.kind    = 4'($urandom_range(0, 15));
        r.subject = rand64();
      end
      sel = $urandom_range(0, 4);
      case (sel)
        0:       r.generation = rand64();
        1, 2:    r.generation = 64'($urandom_range(0, 7));
        3:       r.generation = ~64'($urandom_range(0, 3));
        default: r.generation = TOP_BIT | 64'($urandom_range(0, 7));
      endcase
      sel = $urandom_range(0, 7);
      if (sel == 0) r.epoch = '0;
      else if (sel == 1) r.epoch = ONES;
      else r.epoch = rand64();
      issue_request(r, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* keyed_generation_table_core.f */
+incdir+design
design/kgt_pkg.sv
design/kgt_cell.sv
design/keyed_generation_table_core.sv
sim/keyed_generation_table_core_tb.sv
